### hdl/sidt_pkg.sv
package sidt_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CONV_STEPS = VALUE_W;
  localparam int unsigned STEP_W     = $clog2(CONV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

### hdl/sidt_front.sv
module sidt_front #(
  parameter int unsigned CAP     = 10,
  parameter int unsigned ENTRY_W = 1 + sidt_pkg::COUNT_W + 4 * CAP
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [sidt_pkg::VALUE_W-1:0] value_i,
  output logic                              busy_o,
  input  sidt_pkg::fifo_status_t            fifo_status_i,
  output logic                              push_o,
  output logic [ENTRY_W-1:0]                entry_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_e;

  state_e                           state_q;
  logic                             neg_q;
  logic [sidt_pkg::VALUE_W-1:0]     mag_q;
  logic [sidt_pkg::BCD_W-1:0]       bcd_q;
  logic [sidt_pkg::BCD_W-1:0]       bcd_adj;
  logic [sidt_pkg::STEP_W-1:0]      step_q;
  logic [sidt_pkg::COUNT_W-1:0]     sig_count;
  logic [sidt_pkg::COUNT_W-1:0]     kept_count;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sidt_pkg::BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // significant digits: highest nonzero digit, at least one
  always_comb begin
    sig_count = sidt_pkg::COUNT_W'(1);
    for (int i = 0; i < sidt_pkg::BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        sig_count = sidt_pkg::COUNT_W'(i + 1);
      end
    end
    if (sig_count > sidt_pkg::COUNT_W'(CAP)) begin
      kept_count = sidt_pkg::COUNT_W'(CAP);
    end else begin
      kept_count = sig_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_CONV;
            step_q  <= '0;
          end
        end
        ST_CONV: begin
          step_q <= step_q + 1'b1;
          if (step_q == sidt_pkg::STEP_W'(sidt_pkg::CONV_STEPS - 1)) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!fifo_status_i.full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      neg_q <= value_i[sidt_pkg::VALUE_W-1];
      mag_q <= value_i[sidt_pkg::VALUE_W-1] ? (sidt_pkg::VALUE_W'(0) - value_i) : value_i;
      bcd_q <= '0;
    end else if (state_q == ST_CONV) begin
      {bcd_q, mag_q} <= {bcd_adj[sidt_pkg::BCD_W-2:0], mag_q, 1'b0};
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign push_o  = (state_q == ST_PUSH) && !fifo_status_i.full;
  assign entry_o = {neg_q, kept_count, bcd_q[4*CAP-1:0]};

endmodule

### hdl/sidt_fifo.sv
module sidt_fifo #(
  parameter int unsigned WIDTH = 45
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       rdata_o,
  output sidt_pkg::fifo_status_t status_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q;
  logic                  rd_ptr_q;
  logic [1:0]            fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);

endmodule

### hdl/sidt_back.sv
module sidt_back #(
  parameter int unsigned CAP     = 10,
  parameter int unsigned ENTRY_W = 1 + sidt_pkg::COUNT_W + 4 * CAP
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sidt_pkg::fifo_status_t       fifo_status_i,
  input  logic [ENTRY_W-1:0]           entry_i,
  output logic                         pop_o,
  output logic                         valid_o,
  output logic [sidt_pkg::CHAR_W-1:0]  character_o,
  output logic                         last_o,
  output logic [sidt_pkg::COUNT_W-1:0] digit_count_o
);

  localparam int unsigned IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e                         state_q;
  logic [sidt_pkg::COUNT_W-1:0]   count_q;
  logic [CAP-1:0][3:0]            digits_q;
  logic [IDX_W-1:0]               idx_q;
  logic                           valid_q;
  logic [sidt_pkg::CHAR_W-1:0]    char_q;
  logic                           last_q;
  logic [sidt_pkg::COUNT_W-1:0]   dcount_q;
  logic [sidt_pkg::COUNT_W-1:0]   entry_count;

  assign entry_count = entry_i[4*CAP +: sidt_pkg::COUNT_W];
  assign pop_o       = (state_q == ST_IDLE) && !fifo_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= 1'b0;
      idx_q    <= '0;
      count_q  <= '0;
      digits_q <= '0;
      char_q   <= '0;
      last_q   <= 1'b0;
      dcount_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_status_i.empty) begin
            count_q  <= entry_count;
            digits_q <= entry_i[4*CAP-1:0];
            idx_q    <= IDX_W'(entry_count - sidt_pkg::COUNT_W'(1));
            state_q  <= entry_i[ENTRY_W-1] ? ST_SIGN : ST_DIGITS;
          end
        end
        ST_SIGN: begin
          valid_q  <= 1'b1;
          char_q   <= sidt_pkg::CHAR_MINUS;
          last_q   <= 1'b0;
          dcount_q <= '0;
          state_q  <= ST_DIGITS;
        end
        ST_DIGITS: begin
          valid_q <= 1'b1;
          char_q  <= sidt_pkg::CHAR_ZERO + sidt_pkg::CHAR_W'(digits_q[idx_q]);
          if (idx_q == '0) begin
            last_q   <= 1'b1;
            dcount_q <= count_q;
            state_q  <= ST_IDLE;
          end else begin
            last_q   <= 1'b0;
            dcount_q <= '0;
            idx_q    <= idx_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o       = valid_q;
  assign character_o   = char_q;
  assign last_o        = last_q;
  assign digit_count_o = dcount_q;

endmodule

### hdl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Input: raise start_i with value_i; the word is taken at a rising edge where
// start_i is high and busy_o is low. busy_o stays high while the word is
// converted by a shift-add-3 loop, one bit per cycle.
// Output: one character per strobe on valid_o, most significant first: a '-'
// for negative values, then the digits without leading zeros. last_o marks
// the final character, and digit_count_o carries the number of digits kept
// (sign excluded) on that character, 0 on the other characters. Each strobe lasts one cycle.
// Only the MAX_DIGITS least significant digits are kept when the number is
// longer.
// Each word passes an accept, 32 conversion steps and a hand-off into the
// queue; the hand-off waits while the queue is full, and only after it is a
// new word taken. A two-entry queue lets the next conversion run while the
// character emitter sends up to 11 characters, one per cycle within a word;
// it pops a word first, then registers each character. The receiver cannot stall.
// Reset clears the controllers and the queue; nothing is pending afterwards.
module signed_int_to_decimal_ascii #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sidt_pkg::VALUE_W-1:0] value_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output logic [sidt_pkg::CHAR_W-1:0]         character_o,
  output logic                                last_o,
  output logic [sidt_pkg::COUNT_W-1:0]        digit_count_o
);

  localparam int unsigned CAP     = (MAX_DIGITS > sidt_pkg::BCD_DIGITS) ?
                                    sidt_pkg::BCD_DIGITS :
                                    ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
  localparam int unsigned ENTRY_W = 1 + sidt_pkg::COUNT_W + 4 * CAP;

  sidt_pkg::fifo_status_t fifo_status;
  logic                   push;
  logic                   pop;
  logic [ENTRY_W-1:0]     wr_entry;
  logic [ENTRY_W-1:0]     rd_entry;

  sidt_front #(
    .CAP     (CAP),
    .ENTRY_W (ENTRY_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .entry_o       (wr_entry)
  );

  sidt_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wr_entry),
    .pop_i    (pop),
    .rdata_o  (rd_entry),
    .status_o (fifo_status)
  );

  sidt_back #(
    .CAP     (CAP),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .entry_i       (rd_entry),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .character_o   (character_o),
    .last_o        (last_o),
    .digit_count_o (digit_count_o)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DIGIT_DEPTH = 10;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct packed {
    logic [sidt_pkg::CHAR_W-1:0]  ch;
    logic                         is_last;
    logic [sidt_pkg::COUNT_W-1:0] count;
  } text_char_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start_i;
  logic signed [sidt_pkg::VALUE_W-1:0] value_i;
  logic                                busy_o;
  logic                                valid_o;
  logic [sidt_pkg::CHAR_W-1:0]         character_o;
  logic                                last_o;
  logic [sidt_pkg::COUNT_W-1:0]        digit_count_o;

  text_char_t  expected_chars[$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned stall_cycles = 0;
  bit          idle_enable;

  signed_int_to_decimal_ascii #(
    .MAX_DIGITS(DIGIT_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .valid_o      (valid_o),
    .character_o  (character_o),
    .last_o       (last_o),
    .digit_count_o(digit_count_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // expected text of one word: sign, then kept digits most significant first
  function automatic void predict_text(input logic [sidt_pkg::VALUE_W-1:0] v);
    logic                          neg;
    logic [sidt_pkg::VALUE_W-1:0]  mag;
    logic [3:0]                    digs[10];
    int unsigned                   cap;
    int unsigned                   n;
    text_char_t                    c;
    neg = v[sidt_pkg::VALUE_W-1];
    mag = neg ? (32'd0 - v) : v;
    cap = DIGIT_DEPTH;
    if (cap > 10) cap = 10;
    if (cap < 1) cap = 1;
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < cap);
    if (neg) begin
      c.ch = sidt_pkg::CHAR_MINUS;
      c.is_last = 1'b0;
      c.count = '0;
      expected_chars.push_back(c);
    end
    for (int i = int'(n) - 1; i >= 0; i--) begin
      c.ch = sidt_pkg::CHAR_ZERO + sidt_pkg::CHAR_W'(digs[i]);
      c.is_last = (i == 0);
      c.count = (i == 0) ? sidt_pkg::COUNT_W'(n) : '0;
      expected_chars.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // sender works in bursts; a gap is only inserted between bursts
  task automatic send_value(input logic [sidt_pkg::VALUE_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = 0;
      if (idle_enable && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 45);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_text(v);
    burst_left--;
  endtask

  task automatic wait_text_drained();
    start_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  // random magnitude with exactly n digits, optional sign
  function automatic logic [sidt_pkg::VALUE_W-1:0] value_of_length(input int unsigned n,
                                                                   input bit neg);
    longint unsigned              lo;
    longint unsigned              hi;
    logic [sidt_pkg::VALUE_W-1:0] mag;
    lo = 1;
    for (int i = 1; i < n; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (n == 1) lo = 0;
    if (!neg && hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
    if (neg && hi > 64'h8000_0000) hi = 64'h8000_0000;
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? (32'd0 - mag) : mag;
  endfunction

  task automatic test_directed();
    logic [sidt_pkg::VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd100, -32'sd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             -32'sd1000000000, 32'd999999999, -32'sd999999999, 32'd123456789,
             -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000007};
    idle_enable = 1'b0;
    foreach (vals[i]) send_value(vals[i]);
    wait_text_drained();
  endtask

  task automatic test_digit_lengths();
    idle_enable = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int n = 1; n <= 10; n++) begin
        send_value(value_of_length(n, 1'b0));
        send_value(value_of_length(n, 1'b1));
      end
    end
  endtask

  task automatic test_random_values();
    for (int i = 0; i < 120; i++) begin
      // stretches with the sender never idle
      idle_enable = ((i / 30) % 2) == 0;
      if ($urandom_range(0, 2) == 0) send_value($urandom());
      else send_value(value_of_length($urandom_range(1, 10), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_drain_pauses();
    idle_enable = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_value($urandom());
      if ($urandom_range(0, 3) == 0) wait_text_drained();
    end
    wait_text_drained();
  endtask

  // checker: every strobe is one accepted character
  always @(posedge clk_i) begin
    text_char_t e;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%0h", character_o));
      end else begin
        e = expected_chars.pop_front();
        if (character_o !== e.ch)
          report_mismatch($sformatf("char got 0x%0h exp 0x%0h", character_o, e.ch));
        if (last_o !== e.is_last)
          report_mismatch($sformatf("last got %b exp %b", last_o, e.is_last));
        if (digit_count_o !== e.count)
          report_mismatch($sformatf("count got %0d exp %0d", digit_count_o, e.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    mismatch_count = 0;
    burst_left = 0;
    idle_enable = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_digit_lengths();
    test_random_values();
    test_drain_pauses();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/sidt_pkg.sv
hdl/sidt_front.sv
hdl/sidt_fifo.sv
hdl/sidt_back.sv
hdl/signed_int_to_decimal_ascii.sv
sim/tb.sv
